// ----- rtl/source_tokenizer_assert.svh -----
// Assertion macros used by the tokenizer top level.
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STKN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define STKN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/stkn_pkg.sv -----
// Types, constants and helper functions for the source tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package stkn_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 12;
    localparam int LEN_BITS    = 12;
    localparam int KW_BYTES    = 8;
    localparam int MAX_TOKENS  = 4;

    localparam logic [LINE_BITS-1:0]   LINE_TOP   = '1;
    localparam logic [COLUMN_BITS-1:0] COLUMN_TOP = '1;
    localparam logic [LEN_BITS-1:0]    LEN_TOP    = '1;

    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_RPAREN  = 6'd1;
    localparam logic [5:0] K_LBRACE  = 6'd2;
    localparam logic [5:0] K_RBRACE  = 6'd3;
    localparam logic [5:0] K_LBRACK  = 6'd4;
    localparam logic [5:0] K_RBRACK  = 6'd5;
    localparam logic [5:0] K_COMMA   = 6'd6;
    localparam logic [5:0] K_DOT     = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_PLUS    = 6'd9;
    localparam logic [5:0] K_MINUS   = 6'd10;
    localparam logic [5:0] K_STAR    = 6'd11;
    localparam logic [5:0] K_DIV     = 6'd12;
    localparam logic [5:0] K_ASSIGN  = 6'd13;
    localparam logic [5:0] K_EQ      = 6'd14;
    localparam logic [5:0] K_NOT     = 6'd15;
    localparam logic [5:0] K_NE      = 6'd16;
    localparam logic [5:0] K_LT      = 6'd17;
    localparam logic [5:0] K_LE      = 6'd18;
    localparam logic [5:0] K_GT      = 6'd19;
    localparam logic [5:0] K_GE      = 6'd20;
    localparam logic [5:0] K_AND     = 6'd21;
    localparam logic [5:0] K_OR      = 6'd22;
    localparam logic [5:0] K_NUMBER  = 6'd23;
    localparam logic [5:0] K_STRING  = 6'd24;
    localparam logic [5:0] K_IDENT   = 6'd25;
    localparam logic [5:0] K_KW_BASE = 6'd26;
    localparam logic [5:0] K_COMMENT = 6'd34;
    localparam logic [5:0] K_ERROR   = 6'd35;
    localparam logic [5:0] K_END     = 6'd36;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_UNKNOWN = 3'd1;
    localparam logic [2:0] E_LONE    = 3'd2;
    localparam logic [2:0] E_STRING  = 3'd3;
    localparam logic [2:0] E_COMMENT = 3'd4;

    // keyword text, first byte in the low bits
    localparam logic [8*KW_BYTES-1:0] KW_TEXT [8] = '{
        64'("fi"), 64'("esle"), 64'("elihw"), 64'("rof"),
        64'("nruter"), 64'("noitcnuf"), 64'("eurt"), 64'("eslaf")
    };
    localparam logic [LEN_BITS-1:0] KW_LEN [8] = '{
        12'd2, 12'd4, 12'd5, 12'd3, 12'd6, 12'd8, 12'd4, 12'd5
    };

    typedef struct packed {
        logic [5:0]             kind;
        logic [2:0]             err;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [LEN_BITS-1:0]    len;
    } tok_t;

    typedef struct packed {
        tok_t [MAX_TOKENS-1:0] tok;
        logic [2:0]            count;
    } bundle_t;

    function automatic tok_t mk(input logic [5:0] kind, input logic [2:0] err,
                                input logic [LINE_BITS-1:0] line,
                                input logic [COLUMN_BITS-1:0] col,
                                input logic [LEN_BITS-1:0] len);
        tok_t t;
        t.kind = kind;
        t.err  = err;
        t.line = line;
        t.col  = col;
        t.len  = len;
        return t;
    endfunction

    // appends a token; extra tokens past the fourth are dropped
    function automatic bundle_t push(input bundle_t b, input tok_t t);
        bundle_t r;
        r = b;
        if (r.count < 3'(MAX_TOKENS)) begin
            r.tok[r.count[1:0]] = t;
            r.count = r.count + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [LEN_BITS-1:0] grow(input logic [LEN_BITS-1:0] v);
        return (v == LEN_TOP) ? v : v + 1'b1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [5:0] kw_kind(input logic [8*KW_BYTES-1:0] win,
                                           input logic [LEN_BITS-1:0] len);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 7; i >= 0; i--) begin
            if (len == KW_LEN[i] && win == KW_TEXT[i]) begin
                k = K_KW_BASE + 6'(i);
            end
        end
        return k;
    endfunction

    // single-character form of a held operator
    function automatic tok_t op_one(input logic [7:0] p, input logic [LINE_BITS-1:0] line,
                                    input logic [COLUMN_BITS-1:0] col);
        logic [5:0] k;
        logic [2:0] e;
        k = K_ERROR;
        e = E_NONE;
        unique case (p)
            "=":     k = K_ASSIGN;
            "!":     k = K_NOT;
            "<":     k = K_LT;
            ">":     k = K_GT;
            default: e = E_LONE;
        endcase
        return mk(k, e, line, col, 12'd1);
    endfunction

    function automatic logic [5:0] op_two(input logic [7:0] p);
        logic [5:0] k;
        unique case (p)
            "=":     k = K_EQ;
            "!":     k = K_NE;
            "<":     k = K_LE;
            ">":     k = K_GE;
            "&":     k = K_AND;
            default: k = K_OR;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/stkn_scan.sv -----
// Scanner state and the per-byte step that builds a bundle of tokens.
`timescale 1ns / 1ps
`default_nettype none
module stkn_scan (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              take,
    input  wire logic [7:0]        ch,
    input  wire logic              eot,
    output stkn_pkg::bundle_t      bundle
);

    typedef enum logic [10:0] {
        M_IDLE  = 11'b000_0000_0001,
        M_SLASH = 11'b000_0000_0010,
        M_OP    = 11'b000_0000_0100,
        M_IDENT = 11'b000_0000_1000,
        M_INT   = 11'b000_0001_0000,
        M_DOT   = 11'b000_0010_0000,
        M_FRAC  = 11'b000_0100_0000,
        M_STR   = 11'b000_1000_0000,
        M_LCOM  = 11'b001_0000_0000,
        M_BCOM  = 11'b010_0000_0000,
        M_BSTAR = 11'b100_0000_0000
    } mode_t;

    mode_t                                 mode_reg, mode_next;
    logic [7:0]                            pend_reg, pend_next;
    logic [8*stkn_pkg::KW_BYTES-1:0]       kw_reg, kw_next;
    logic [stkn_pkg::LEN_BITS-1:0]         run_reg, run_next;
    logic [stkn_pkg::LINE_BITS-1:0]        tl_reg, tl_next, ln_reg, ln_next;
    logic [stkn_pkg::COLUMN_BITS-1:0]      tc_reg, tc_next, cn_reg, cn_next;

    always_comb begin
        stkn_pkg::bundle_t b;
        logic [7:0] want;
        logic [stkn_pkg::COLUMN_BITS:0] dsum;
        logic [stkn_pkg::COLUMN_BITS-1:0] dcol;
        logic restart;
        b = '0;
        restart = 1'b0;
        mode_next = mode_reg;
        pend_next = pend_reg;
        kw_next = kw_reg;
        run_next = run_reg;
        tl_next = tl_reg;
        tc_next = tc_reg;
        want = (pend_reg == "&" || pend_reg == "|") ? pend_reg : 8'("=");
        // column of the dot after a number, saturating
        dsum = {1'b0, tc_reg} + (stkn_pkg::COLUMN_BITS + 1)'(run_reg);
        dcol = dsum[stkn_pkg::COLUMN_BITS] ? stkn_pkg::COLUMN_TOP
                                           : dsum[stkn_pkg::COLUMN_BITS-1:0];

        unique case (mode_reg)
            M_SLASH: begin
                if (ch == "/") begin
                    run_next = 12'd2;
                    mode_next = M_LCOM;
                end else if (ch == "*") begin
                    run_next = 12'd2;
                    mode_next = M_BCOM;
                end else begin
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_DIV, stkn_pkg::E_NONE,
                                                       tl_reg, tc_reg, 12'd1));
                    restart = 1'b1;
                end
            end
            M_OP: begin
                if (ch == want) begin
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::op_two(pend_reg),
                                                       stkn_pkg::E_NONE, tl_reg, tc_reg, 12'd2));
                    mode_next = M_IDLE;
                end else begin
                    b = stkn_pkg::push(b, stkn_pkg::op_one(pend_reg, tl_reg, tc_reg));
                    restart = 1'b1;
                end
            end
            M_IDENT: begin
                if (stkn_pkg::is_alpha(ch) || stkn_pkg::is_digit(ch)) begin
                    if (run_reg < 12'(stkn_pkg::KW_BYTES)) begin
                        kw_next[{run_reg[2:0], 3'b000} +: 8] = ch;
                    end
                    run_next = stkn_pkg::grow(run_reg);
                end else begin
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::kw_kind(kw_reg, run_reg),
                                                       stkn_pkg::E_NONE, tl_reg, tc_reg, run_reg));
                    restart = 1'b1;
                end
            end
            M_INT: begin
                if (stkn_pkg::is_digit(ch)) begin
                    run_next = stkn_pkg::grow(run_reg);
                end else if (ch == ".") begin
                    mode_next = M_DOT;
                end else begin
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_NUMBER, stkn_pkg::E_NONE,
                                                       tl_reg, tc_reg, run_reg));
                    restart = 1'b1;
                end
            end
            M_DOT: begin
                if (stkn_pkg::is_digit(ch)) begin
                    run_next = stkn_pkg::grow(stkn_pkg::grow(run_reg));
                    mode_next = M_FRAC;
                end else begin
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_NUMBER, stkn_pkg::E_NONE,
                                                       tl_reg, tc_reg, run_reg));
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_DOT, stkn_pkg::E_NONE,
                                                       tl_reg, dcol, 12'd1));
                    restart = 1'b1;
                end
            end
            M_FRAC: begin
                if (stkn_pkg::is_digit(ch)) begin
                    run_next = stkn_pkg::grow(run_reg);
                end else begin
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_NUMBER, stkn_pkg::E_NONE,
                                                       tl_reg, tc_reg, run_reg));
                    restart = 1'b1;
                end
            end
            M_STR: begin
                if (ch == "\"") begin
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_STRING, stkn_pkg::E_NONE,
                                                       tl_reg, tc_reg, run_reg));
                    mode_next = M_IDLE;
                end else begin
                    run_next = stkn_pkg::grow(run_reg);
                end
            end
            M_LCOM: begin
                if (ch == 8'h0a) begin
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_COMMENT, stkn_pkg::E_NONE,
                                                       tl_reg, tc_reg, run_reg));
                    mode_next = M_IDLE;
                end else begin
                    run_next = stkn_pkg::grow(run_reg);
                end
            end
            M_BCOM: begin
                run_next = stkn_pkg::grow(run_reg);
                if (ch == "*") begin
                    mode_next = M_BSTAR;
                end
            end
            M_BSTAR: begin
                run_next = stkn_pkg::grow(run_reg);
                if (ch == "/") begin
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_COMMENT, stkn_pkg::E_NONE,
                                                       tl_reg, tc_reg, run_next));
                    mode_next = M_IDLE;
                end else if (ch != "*") begin
                    mode_next = M_BCOM;
                end
            end
            default: restart = 1'b1;
        endcase

        // byte starts a new token
        if (restart) begin
            mode_next = M_IDLE;
            tl_next = ln_reg;
            tc_next = cn_reg;
            run_next = 12'd1;
            priority case (ch)
                " ", 8'h09, 8'h0d, 8'h0a: ;
                "(": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_LPAREN, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                ")": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_RPAREN, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                "{": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_LBRACE, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                "}": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_RBRACE, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                "[": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_LBRACK, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                "]": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_RBRACK, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                ",": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_COMMA, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                ".": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_DOT, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                ";": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_SEMI, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                "+": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_PLUS, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                "-": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_MINUS, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                "*": b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_STAR, stkn_pkg::E_NONE,
                                                        ln_reg, cn_reg, 12'd1));
                "/": mode_next = M_SLASH;
                "=", "!", "<", ">", "&", "|": begin
                    pend_next = ch;
                    mode_next = M_OP;
                end
                "\"": begin
                    run_next = '0;
                    mode_next = M_STR;
                end
                default: begin
                    if (stkn_pkg::is_digit(ch)) begin
                        mode_next = M_INT;
                    end else if (stkn_pkg::is_alpha(ch)) begin
                        kw_next = {{(8*stkn_pkg::KW_BYTES-8){1'b0}}, ch};
                        mode_next = M_IDENT;
                    end else begin
                        b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_ERROR,
                                                           stkn_pkg::E_UNKNOWN,
                                                           ln_reg, cn_reg, 12'd1));
                    end
                end
            endcase
        end

        // position after this byte
        if (ch == 8'h0a) begin
            ln_next = (ln_reg == stkn_pkg::LINE_TOP) ? ln_reg : ln_reg + 1'b1;
            cn_next = 12'd1;
        end else begin
            ln_next = ln_reg;
            cn_next = (cn_reg == stkn_pkg::COLUMN_TOP) ? cn_reg : cn_reg + 1'b1;
        end

        // final byte: flush, end token, back to reset state
        if (eot) begin
            unique case (mode_next)
                M_SLASH: b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_DIV, stkn_pkg::E_NONE,
                                                            tl_next, tc_next, 12'd1));
                M_OP:    b = stkn_pkg::push(b, stkn_pkg::op_one(pend_next, tl_next, tc_next));
                M_IDENT: b = stkn_pkg::push(b, stkn_pkg::mk(
                                 stkn_pkg::kw_kind(kw_next, run_next), stkn_pkg::E_NONE,
                                 tl_next, tc_next, run_next));
                M_INT, M_FRAC: b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_NUMBER,
                                 stkn_pkg::E_NONE, tl_next, tc_next, run_next));
                M_DOT: begin
                    dsum = {1'b0, tc_next} + (stkn_pkg::COLUMN_BITS + 1)'(run_next);
                    dcol = dsum[stkn_pkg::COLUMN_BITS] ? stkn_pkg::COLUMN_TOP
                                                       : dsum[stkn_pkg::COLUMN_BITS-1:0];
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_NUMBER, stkn_pkg::E_NONE,
                                                       tl_next, tc_next, run_next));
                    b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_DOT, stkn_pkg::E_NONE,
                                                       tl_next, dcol, 12'd1));
                end
                M_STR:  b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_ERROR,
                                 stkn_pkg::E_STRING, tl_next, tc_next, run_next));
                M_LCOM: b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_COMMENT,
                                 stkn_pkg::E_NONE, tl_next, tc_next, run_next));
                M_BCOM, M_BSTAR: b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_ERROR,
                                 stkn_pkg::E_COMMENT, tl_next, tc_next, run_next));
                default: ;
            endcase
            b = stkn_pkg::push(b, stkn_pkg::mk(stkn_pkg::K_END, stkn_pkg::E_NONE,
                                               ln_next, cn_next, '0));
            mode_next = M_IDLE;
            pend_next = '0;
            kw_next = '0;
            run_next = '0;
            tl_next = 16'd1;
            tc_next = 12'd1;
            ln_next = 16'd1;
            cn_next = 12'd1;
        end
        bundle = b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            pend_reg <= '0;
            kw_reg <= '0;
            run_reg <= '0;
            tl_reg <= 16'd1;
            tc_reg <= 12'd1;
            ln_reg <= 16'd1;
            cn_reg <= 12'd1;
        end else if (take) begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            kw_reg <= kw_next;
            run_reg <= run_next;
            tl_reg <= tl_next;
            tc_reg <= tc_next;
            ln_reg <= ln_next;
            cn_reg <= cn_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/stkn_emit.sv -----
// Result register: holds one byte's token bundle and sends it a beat at a time.
`timescale 1ns / 1ps
`default_nettype none
module stkn_emit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire stkn_pkg::bundle_t in_bundle,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output stkn_pkg::tok_t         out_tok,
    output logic                   out_last
);

    stkn_pkg::bundle_t bnd_reg;
    logic [1:0]        idx_reg;
    logic              valid_reg;
    logic              final_beat;

    assign out_valid = valid_reg;
    assign out_tok   = bnd_reg.tok[idx_reg];
    assign out_last  = ({1'b0, idx_reg} + 3'd1) == bnd_reg.count;
    assign final_beat = valid_reg && out_ready && out_last;
    assign in_ready  = !valid_reg || final_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
        end else if (in_valid && in_ready && in_bundle.count != 3'd0) begin
            valid_reg <= 1'b1;
            idx_reg <= '0;
        end else if (final_beat) begin
            valid_reg <= 1'b0;
        end else if (valid_reg && out_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready && in_bundle.count != 3'd0) begin
            bnd_reg <= in_bundle;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/source_tokenizer.sv -----
// Source tokenizer top level: byte stream in, token stream out.
//
// Input: one source byte per beat on s_tdata; s_tlast marks the final byte
// of a text. Output: one token per beat, m_tlast set on the last token
// caused by a given byte. A byte's tokens (zero to four) are computed
// combinationally from the scanner state and loaded into the result register.
// Latency: first token of a byte appears the cycle after the byte's beat.
// Throughput: one byte per cycle while m_tready is high and each byte yields
// at most one token; a byte yielding more tokens holds the input until they
// are all sent, since the result register drains one token per beat. A byte
// is taken only while the result register is empty or its final token goes
// out in that cycle, whether or not the byte itself yields a token.
// A stalled m_tready holds the current token and deasserts s_tready until
// that byte's last token is taken. Reset clears the scanner to line 1,
// column 1 with no pending token and empties the result register. After
// the final byte the scanner returns to that same state by itself.
`timescale 1ns / 1ps
`default_nettype none
`include "source_tokenizer_assert.svh"
module source_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [5:0] token_kind, [8:6] error_kind, [24:9] start_line,
    // [36:25] start_column, [48:37] token_length, [55:49] zero
    output logic [55:0]      m_tdata,
    output logic             m_tlast
);

    stkn_pkg::bundle_t bundle;
    stkn_pkg::tok_t    tok;
    logic              take;

    assign take = s_tvalid && s_tready;

    stkn_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .ch      (s_tdata),
        .eot     (s_tlast),
        .bundle  (bundle)
    );

    stkn_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_bundle (bundle),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (tok),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'd0, tok.len, tok.col, tok.line, tok.err, tok.kind};

    `STKN_ASSERT_NOW(a_idle_ready, !m_tvalid, s_tready, "input blocked with empty output")
    `STKN_ASSERT_NOW(a_end_is_last, m_tvalid && tok.kind == stkn_pkg::K_END, m_tlast,
                     "end token not last of its byte")
    `STKN_ASSERT_NOW(a_err_only_error, m_tvalid && tok.kind != stkn_pkg::K_ERROR,
                     tok.err == stkn_pkg::E_NONE, "error kind on a non-error token")
    `STKN_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                      "stalled token changed")

endmodule
`default_nettype wire
